FILE: rtl/kses_pkg.sv
// kses_pkg: shared sizes and types for the key to escape sequence encoder
// holds the queue entry and queue status types; no dependencies
`default_nettype none

package kses_pkg;

  // longest sequence the encoder ever builds, and the width of its length
  localparam int SEQ_MAX = 7;
  localparam int LEN_W = 3;

  // default depth of the queue between front and back
  localparam int KSES_QUEUE_DEPTH = 4;

  // escape introducer, used wherever a sequence is built or checked
  localparam logic [7:0] ESC_BYTE = 8'h1B;

  // one encoded key: bytes in send order, and how many are valid
  typedef struct packed {
    logic [SEQ_MAX-1:0][7:0] bytes;
    logic [LEN_W-1:0]        len;
  } kses_entry_t;

  // queue status seen by front and back
  typedef struct packed {
    logic full;
    logic empty;
  } kses_q_stat_t;

endpackage : kses_pkg

`default_nettype wire

FILE: rtl/kses_front.sv
// kses_front: classifies one key event and builds its whole byte sequence
// depends on kses_pkg; feeds kses_queue
`default_nettype none

module kses_front
  import kses_pkg::*;
(
  input  wire logic                 push,
  input  wire logic [7:0]           key_code,
  input  wire logic [2:0]           modifier_bits,
  input  wire logic                 has_text,
  input  wire logic [20:0]          text_code_point,
  input  wire logic                 app_cursor_mode,
  input  wire kses_q_stat_t         q_stat,
  output logic                      wr_en,
  output kses_entry_t               wr_data
);

  localparam logic [7:0] K_RETURN  = 8'h8A;
  localparam logic [7:0] K_ENTER   = 8'h8B;
  localparam logic [7:0] K_TAB     = 8'h8C;
  localparam logic [7:0] K_BACKTAB = 8'h8D;
  localparam logic [7:0] K_ESCAPE  = 8'h8E;
  localparam logic [7:0] K_BKSP    = 8'h8F;
  localparam logic [7:0] K_SPACE   = 8'h20;

  // final byte of a cursor key
  function automatic logic [7:0] cursor_final(input logic [2:0] k);
    case (k)
      3'd0:    cursor_final = 8'h41;
      3'd1:    cursor_final = 8'h42;
      3'd2:    cursor_final = 8'h43;
      3'd3:    cursor_final = 8'h44;
      3'd4:    cursor_final = 8'h48;
      3'd5:    cursor_final = 8'h46;
      default: cursor_final = 8'h00;
    endcase
  endfunction

  // tilde number as {two digit flag, tens digit, ones digit}
  function automatic logic [8:0] tilde_num(input logic [7:0] k);
    case (k)
      8'h86:   tilde_num = {1'b0, 4'd0, 4'd2};
      8'h87:   tilde_num = {1'b0, 4'd0, 4'd3};
      8'h88:   tilde_num = {1'b0, 4'd0, 4'd5};
      8'h89:   tilde_num = {1'b0, 4'd0, 4'd6};
      8'h94:   tilde_num = {1'b1, 4'd1, 4'd5};
      8'h95:   tilde_num = {1'b1, 4'd1, 4'd7};
      8'h96:   tilde_num = {1'b1, 4'd1, 4'd8};
      8'h97:   tilde_num = {1'b1, 4'd1, 4'd9};
      8'h98:   tilde_num = {1'b1, 4'd2, 4'd0};
      8'h99:   tilde_num = {1'b1, 4'd2, 4'd1};
      8'h9A:   tilde_num = {1'b1, 4'd2, 4'd3};
      8'h9B:   tilde_num = {1'b1, 4'd2, 4'd4};
      default: tilde_num = {1'b0, 4'd0, 4'd0};
    endcase
  endfunction

  logic [7:0] b [SEQ_MAX];

  always_comb begin
    logic [LEN_W-1:0] n;
    logic             alt;
    logic             ctrl;
    logic [7:0]       mod_digit;
    logic [7:0]       fin;
    logic [8:0]       tn;
    logic [7:0]       c0;
    logic [20:0]      cp;

    for (int i = 0; i < SEQ_MAX; i++) begin
      b[i] = 8'h00;
    end
    n = '0;
    alt = modifier_bits[1];
    ctrl = modifier_bits[2];
    // parameter is modifiers plus one, always a single digit
    mod_digit = 8'h31 + {5'b0, modifier_bits};
    fin = 8'h00;
    tn = tilde_num(key_code);
    c0 = 8'h00;
    cp = text_code_point;
    if (cp > 21'h10FFFF || (cp >= 21'h00D800 && cp <= 21'h00DFFF)) begin
      cp = 21'h00FFFD;
    end

    case (key_code)
      8'h5B:        c0 = 8'h1B;
      8'h5C:        c0 = 8'h1C;
      8'h5D:        c0 = 8'h1D;
      8'h5E, 8'h36: c0 = 8'h1E;
      8'h5F, 8'h2D: c0 = 8'h1F;
      default:      c0 = 8'h00;
    endcase

    if (key_code inside {[8'h80:8'h85], [8'h90:8'h93]}) begin
      // cursor keys and F1-F4
      fin = key_code[4] ? (8'h50 + {6'b0, key_code[1:0]}) : cursor_final(key_code[2:0]);
      b[n] = ESC_BYTE; n = n + 1'b1;
      if (modifier_bits != 3'd0) begin
        b[n] = 8'h5B; n = n + 1'b1;
        b[n] = 8'h31; n = n + 1'b1;
        b[n] = 8'h3B; n = n + 1'b1;
        b[n] = mod_digit; n = n + 1'b1;
      end else begin
        b[n] = (key_code[4] || app_cursor_mode) ? 8'h4F : 8'h5B; n = n + 1'b1;
      end
      b[n] = fin; n = n + 1'b1;
    end else if (key_code inside {[8'h86:8'h89], [8'h94:8'h9B]}) begin
      // editing keys and F5-F12
      b[n] = ESC_BYTE; n = n + 1'b1;
      b[n] = 8'h5B; n = n + 1'b1;
      if (tn[8]) begin
        b[n] = 8'h30 + {4'b0, tn[7:4]}; n = n + 1'b1;
      end
      b[n] = 8'h30 + {4'b0, tn[3:0]}; n = n + 1'b1;
      if (modifier_bits != 3'd0) begin
        b[n] = 8'h3B; n = n + 1'b1;
        b[n] = mod_digit; n = n + 1'b1;
      end
      b[n] = 8'h7E; n = n + 1'b1;
    end else if (key_code inside {[8'h9C:8'hA3]}) begin
      // bare modifier keys send nothing
      n = '0;
    end else if (key_code == K_BACKTAB) begin
      b[n] = ESC_BYTE; n = n + 1'b1;
      b[n] = 8'h5B; n = n + 1'b1;
      b[n] = 8'h5A; n = n + 1'b1;
    end else if (key_code == K_ESCAPE) begin
      b[n] = ESC_BYTE; n = n + 1'b1;
    end else if (key_code == K_RETURN || key_code == K_ENTER || key_code == K_TAB
                 || key_code == K_BKSP || (ctrl && key_code == K_SPACE)
                 || (ctrl && key_code inside {[8'h41:8'h5A]})
                 || (ctrl && c0 != 8'h00)) begin
      // single fixed code, escape prefix under alt
      if (alt) begin
        b[n] = ESC_BYTE; n = n + 1'b1;
      end
      if (key_code == K_RETURN || key_code == K_ENTER) begin
        b[n] = 8'h0D;
      end else if (key_code == K_TAB) begin
        b[n] = 8'h09;
      end else if (key_code == K_BKSP) begin
        b[n] = ctrl ? 8'h08 : 8'h7F;
      end else if (key_code == K_SPACE) begin
        b[n] = 8'h00;
      end else if (key_code inside {[8'h41:8'h5A]}) begin
        b[n] = {3'b000, key_code[4:0]};
      end else begin
        b[n] = c0;
      end
      n = n + 1'b1;
    end else if (has_text) begin
      if (alt) begin
        b[n] = ESC_BYTE; n = n + 1'b1;
      end
      if (cp < 21'h80) begin
        b[n] = cp[7:0]; n = n + 1'b1;
      end else if (cp < 21'h800) begin
        b[n] = {3'b110, cp[10:6]}; n = n + 1'b1;
        b[n] = {2'b10, cp[5:0]}; n = n + 1'b1;
      end else if (cp < 21'h10000) begin
        b[n] = {4'b1110, cp[15:12]}; n = n + 1'b1;
        b[n] = {2'b10, cp[11:6]}; n = n + 1'b1;
        b[n] = {2'b10, cp[5:0]}; n = n + 1'b1;
      end else begin
        b[n] = {5'b11110, cp[20:18]}; n = n + 1'b1;
        b[n] = {2'b10, cp[17:12]}; n = n + 1'b1;
        b[n] = {2'b10, cp[11:6]}; n = n + 1'b1;
        b[n] = {2'b10, cp[5:0]}; n = n + 1'b1;
      end
    end

    for (int i = 0; i < SEQ_MAX; i++) begin
      wr_data.bytes[i] = b[i];
    end
    wr_data.len = n;
  end

  // empty sequences never enter the queue
  assign wr_en = push && !q_stat.full && (wr_data.len != '0);

endmodule : kses_front

`default_nettype wire

FILE: rtl/kses_queue.sv
// kses_queue: small queue of encoded sequences between front and back
// depends on kses_pkg; read data is registered and held until the next read
`default_nettype none

module kses_queue
  import kses_pkg::*;
#(
  parameter int DEPTH = KSES_QUEUE_DEPTH
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         wr_en,
  input  wire kses_entry_t  wr_data,
  input  wire logic         rd_en,
  output kses_entry_t       rd_data,
  output kses_q_stat_t      q_stat
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  kses_entry_t   mem [DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [CW-1:0] count;

  assign q_stat.full  = (count == CW'(DEPTH));
  assign q_stat.empty = (count == '0);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_ptr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_ptr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (rd_en) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (wr_en && !rd_en) begin
        count <= count + 1'b1;
      end else if (rd_en && !wr_en) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule : kses_queue

`default_nettype wire

FILE: rtl/kses_back.sv
// kses_back: sends the bytes of the current queue entry one per request
// depends on kses_pkg; works from the registered read data of kses_queue
`default_nettype none

module kses_back
  import kses_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         pop,
  input  wire kses_q_stat_t q_stat,
  input  wire kses_entry_t  rd_data,
  output logic              rd_en,
  output logic              empty,
  output logic [7:0]        out_byte,
  output logic              last_byte
);

  logic             busy;
  logic [LEN_W-1:0] idx;

  assign empty     = !busy;
  assign out_byte  = rd_data.bytes[idx];
  assign last_byte = ((idx + 1'b1) == rd_data.len);

  // fetch the next entry when idle or as the last byte leaves
  assign rd_en = (!busy || (pop && last_byte)) && !q_stat.empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      idx  <= '0;
    end else if (rd_en) begin
      busy <= 1'b1;
      idx  <= '0;
    end else if (busy && pop) begin
      if (last_byte) begin
        busy <= 1'b0;
      end else begin
        idx <= idx + 1'b1;
      end
    end
  end

endmodule : kses_back

`default_nettype wire

FILE: rtl/key_to_escape_sequence_encoder_unit.sv
// key_to_escape_sequence_encoder_unit: top level of the key encoder
// depends on kses_pkg, kses_front, kses_queue and kses_back
//
//   channel   signals                                          handshake
//   -------   ----------------------------------------------   ----------------
//   key in    key_code modifier_bits has_text text_code_point  push / full
//   bytes out out_byte last_byte                               empty / pop
//   config    app_cursor_mode                                  cfg_valid / cfg_ready
//
// a key is classified and fully encoded in the cycle it is pushed; a new key
// can be pushed every cycle while the queue of QUEUE_DEPTH sequences has room
// the back end sends one byte per cycle while pop is high, 1 to 7 bytes per key;
// a taken key is written into the queue and then read into its registered read
// data, from which the first byte is shown on the outputs and can be popped
// synchronous reset empties the queue and clears the cursor mode bit
// full rises only when the queue is full; a stalled output holds its byte
`default_nettype none

module key_to_escape_sequence_encoder_unit
  import kses_pkg::*;
#(
  parameter int QUEUE_DEPTH = KSES_QUEUE_DEPTH
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // key events
  input  wire logic        push,
  output logic             full,
  input  wire logic [7:0]  key_code,
  input  wire logic [2:0]  modifier_bits,
  input  wire logic        has_text,
  input  wire logic [20:0] text_code_point,
  // encoded bytes
  output logic             empty,
  input  wire logic        pop,
  output logic [7:0]       out_byte,
  output logic             last_byte,
  // cursor mode register
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic        app_cursor_mode
);

  logic         acm;      // application cursor mode
  logic         wr_en;
  logic         rd_en;
  kses_entry_t  wr_data;
  kses_entry_t  rd_data;
  kses_q_stat_t q_stat;

  // register is always writable
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      acm <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      acm <= app_cursor_mode;
    end
  end

  // the front never blocks except on a full queue
  assign full = q_stat.full;

  // classify and build the sequence
  kses_front u_front (
    .push            (push),
    .key_code        (key_code),
    .modifier_bits   (modifier_bits),
    .has_text        (has_text),
    .text_code_point (text_code_point),
    .app_cursor_mode (acm),
    .q_stat          (q_stat),
    .wr_en           (wr_en),
    .wr_data         (wr_data)
  );

  // decouples key intake from byte delivery
  kses_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (wr_en),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_data (rd_data),
    .q_stat  (q_stat)
  );

  // serialize one byte per request
  kses_back u_back (
    .clk       (clk),
    .rst       (rst),
    .pop       (pop),
    .q_stat    (q_stat),
    .rd_data   (rd_data),
    .rd_en     (rd_en),
    .empty     (empty),
    .out_byte  (out_byte),
    .last_byte (last_byte)
  );

endmodule : key_to_escape_sequence_encoder_unit

`default_nettype wire

FILE: rtl/kses_checker.sv
// kses_checker: port level checks of the key encoder over time
// binds to key_to_escape_sequence_encoder_unit; no package use
`default_nettype none

module kses_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       full,
  input wire logic       empty,
  input wire logic       pop,
  input wire logic [7:0] out_byte,
  input wire logic       last_byte
);

  // reset leaves no bytes to send
  a_rst_empty: assert property (@(posedge clk) rst |=> empty)
    else $error("output not empty after reset");

  // reset leaves room for keys
  a_rst_not_full: assert property (@(posedge clk) rst |=> !full)
    else $error("full after reset");

  // a sequence never stops before its marked last byte
  a_seq_continues: assert property (@(posedge clk) disable iff (rst)
    (!empty && pop && !last_byte) |=> !empty)
    else $error("sequence cut short before last byte");

  // a byte not taken stays put
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(out_byte) && $stable(last_byte)))
    else $error("stalled byte changed");

endmodule : kses_checker

bind key_to_escape_sequence_encoder_unit kses_checker u_kses_checker (
  .clk       (clk),
  .rst       (rst),
  .full      (full),
  .empty     (empty),
  .pop       (pop),
  .out_byte  (out_byte),
  .last_byte (last_byte)
);

`default_nettype wire

FILE: sim/kses_sequence_checker.sv
// key code names for the testbench, and the byte stream checker of the key encoder
// predicts the bytes of every pushed key and compares them with the popped bytes
// depends on kses_pkg for ESC_BYTE and SEQ_MAX
package kses_tb_keys_pkg;

  localparam logic [7:0] KC_SPACE       = 8'h20;
  localparam logic [7:0] KC_UP          = 8'h80;
  localparam logic [7:0] KC_DOWN        = 8'h81;
  localparam logic [7:0] KC_RIGHT       = 8'h82;
  localparam logic [7:0] KC_LEFT        = 8'h83;
  localparam logic [7:0] KC_HOME        = 8'h84;
  localparam logic [7:0] KC_END         = 8'h85;
  localparam logic [7:0] KC_INSERT      = 8'h86;
  localparam logic [7:0] KC_DELETE      = 8'h87;
  localparam logic [7:0] KC_PAGE_UP     = 8'h88;
  localparam logic [7:0] KC_PAGE_DOWN   = 8'h89;
  localparam logic [7:0] KC_RETURN      = 8'h8A;
  localparam logic [7:0] KC_ENTER       = 8'h8B;
  localparam logic [7:0] KC_TAB         = 8'h8C;
  localparam logic [7:0] KC_BACKTAB     = 8'h8D;
  localparam logic [7:0] KC_ESCAPE      = 8'h8E;
  localparam logic [7:0] KC_BACKSPACE   = 8'h8F;
  localparam logic [7:0] KC_F1          = 8'h90;
  localparam logic [7:0] KC_F4          = 8'h93;
  localparam logic [7:0] KC_F5          = 8'h94;
  localparam logic [7:0] KC_F12         = 8'h9B;
  localparam logic [7:0] KC_SHIFT       = 8'h9C;
  localparam logic [7:0] KC_SCROLL_LOCK = 8'hA3;

  localparam logic [2:0] MOD_NONE  = 3'b000;
  localparam logic [2:0] MOD_SHIFT = 3'b001;
  localparam logic [2:0] MOD_ALT   = 3'b010;
  localparam logic [2:0] MOD_CTRL  = 3'b100;
  localparam logic [2:0] MOD_ALL   = 3'b111;

endpackage : kses_tb_keys_pkg

module kses_sequence_checker
  import kses_pkg::*;
  import kses_tb_keys_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  input  logic        full,
  input  logic [7:0]  key_code,
  input  logic [2:0]  modifier_bits,
  input  logic        has_text,
  input  logic [20:0] text_code_point,
  input  logic        empty,
  input  logic        pop,
  input  logic [7:0]  out_byte,
  input  logic        last_byte,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic        app_cursor_mode,
  output int          mismatch_count,
  output int          bytes_pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [7:0] value;
    logic       tail;
  } sent_byte_t;

  sent_byte_t expected_bytes[$];
  sent_byte_t oldest;
  logic       cursor_app = 1'b0;
  logic [7:0] seq_buf[SEQ_MAX];
  int         seq_len = 0;

  task automatic report_mismatch(input string what, input logic [7:0] got,
                                 input logic [7:0] want);
    $display("%0t mismatch on %s: got %h, want %h", $realtime, what, got, want);
    mismatch_count++;
  endtask

  function automatic void put_byte(input logic [7:0] b);
    if (seq_len < SEQ_MAX) begin
      seq_buf[seq_len] = b;
      seq_len++;
    end
  endfunction

  function automatic void put_decimal(input int v);
    if (v >= 10)
      put_byte("0" + 8'((v / 10) % 10));
    put_byte("0" + 8'(v % 10));
  endfunction

  function automatic void put_csi();
    put_byte(ESC_BYTE);
    put_byte("[");
  endfunction

  function automatic void put_tilde(input int num, input int mod);
    put_csi();
    put_decimal(num);
    if (mod > 1) begin
      put_byte(";");
      put_decimal(mod);
    end
    put_byte("~");
  endfunction

  function automatic void put_modified(input logic [7:0] fin, input int mod);
    put_csi();
    put_byte("1");
    put_byte(";");
    put_decimal(mod);
    put_byte(fin);
  endfunction

  function automatic void put_alt(input logic alt, input logic [7:0] b);
    if (alt)
      put_byte(ESC_BYTE);
    put_byte(b);
  endfunction

  // fills seq_buf with the bytes a key event sends to the host
  function automatic void encode_key(input logic [7:0] key, input logic [2:0] mods,
                                     input logic text, input logic [20:0] cp_in,
                                     input logic app_mode);
    logic        alt;
    logic        ctrl;
    int          mod;
    int          num;
    logic [7:0]  fin;
    logic [7:0]  c0;
    logic [20:0] cp;
    alt = mods[1];
    ctrl = mods[2];
    mod = int'(mods) + 1;
    cp = cp_in;
    seq_len = 0;
    case (key)
      8'h5B: c0 = 8'h1B;          // [
      8'h5C: c0 = 8'h1C;          // backslash
      8'h5D: c0 = 8'h1D;          // ]
      8'h5E, 8'h36: c0 = 8'h1E;   // ^ and 6
      8'h5F, 8'h2D: c0 = 8'h1F;   // _ and -
      default: c0 = 8'h00;
    endcase

    if (key >= KC_UP && key <= KC_END) begin
      case (key)
        KC_UP:    fin = "A";
        KC_DOWN:  fin = "B";
        KC_RIGHT: fin = "C";
        KC_LEFT:  fin = "D";
        KC_HOME:  fin = "H";
        default:  fin = "F";
      endcase
      if (mod > 1) begin
        put_modified(fin, mod);
      end else begin
        put_byte(ESC_BYTE);
        put_byte(app_mode ? "O" : "[");
        put_byte(fin);
      end
    end else if (key >= KC_INSERT && key <= KC_PAGE_DOWN) begin
      case (key)
        KC_INSERT:  num = 2;
        KC_DELETE:  num = 3;
        KC_PAGE_UP: num = 5;
        default:    num = 6;
      endcase
      put_tilde(num, mod);
    end else if (key >= KC_F1 && key <= KC_F4) begin
      fin = "P" + (key - KC_F1);
      if (mod > 1) begin
        put_modified(fin, mod);
      end else begin
        put_byte(ESC_BYTE);
        put_byte("O");
        put_byte(fin);
      end
    end else if (key >= KC_F5 && key <= KC_F12) begin
      case (key - KC_F5)
        8'd0:    num = 15;
        8'd1:    num = 17;
        8'd2:    num = 18;
        8'd3:    num = 19;
        8'd4:    num = 20;
        8'd5:    num = 21;
        8'd6:    num = 23;
        default: num = 24;
      endcase
      put_tilde(num, mod);
    end else if (key >= KC_SHIFT && key <= KC_SCROLL_LOCK) begin
      // bare modifier and lock keys send nothing
    end else if (key == KC_RETURN || key == KC_ENTER) begin
      put_alt(alt, 8'h0D);
    end else if (key == KC_TAB) begin
      put_alt(alt, 8'h09);
    end else if (key == KC_BACKTAB) begin
      put_csi();
      put_byte("Z");
    end else if (key == KC_ESCAPE) begin
      put_byte(ESC_BYTE);
    end else if (key == KC_BACKSPACE) begin
      put_alt(alt, ctrl ? 8'h08 : 8'h7F);
    end else if (ctrl && key == KC_SPACE) begin
      put_alt(alt, 8'h00);
    end else if (ctrl && key >= 8'h41 && key <= 8'h5A) begin
      put_alt(alt, key - 8'h40);
    end else if (ctrl && c0 != 8'h00) begin
      put_alt(alt, c0);
    end else if (text) begin
      if (alt)
        put_byte(ESC_BYTE);
      if (cp > 21'h10FFFF || (cp >= 21'h00D800 && cp <= 21'h00DFFF))
        cp = 21'h00FFFD;
      if (cp < 21'h000080) begin
        put_byte(cp[7:0]);
      end else if (cp < 21'h000800) begin
        put_byte({3'b110, cp[10:6]});
        put_byte({2'b10, cp[5:0]});
      end else if (cp < 21'h010000) begin
        put_byte({4'b1110, cp[15:12]});
        put_byte({2'b10, cp[11:6]});
        put_byte({2'b10, cp[5:0]});
      end else begin
        put_byte({5'b11110, cp[20:18]});
        put_byte({2'b10, cp[17:12]});
        put_byte({2'b10, cp[11:6]});
        put_byte({2'b10, cp[5:0]});
      end
    end
  endfunction

  // the popped byte is checked before the pushed key is added: a key never
  // shows on the output in the cycle it is pushed
  always @(posedge clk) begin
    if (rst) begin
      cursor_app = 1'b0;
      expected_bytes.delete();
    end else begin
      if (pop && !empty) begin
        if (expected_bytes.size() == 0) begin
          report_mismatch("unexpected byte", out_byte, 8'h00);
        end else begin
          oldest = expected_bytes.pop_front();
          if (out_byte !== oldest.value)
            report_mismatch("out_byte", out_byte, oldest.value);
          if (last_byte !== oldest.tail)
            report_mismatch("last_byte", 8'(last_byte), 8'(oldest.tail));
        end
      end
      if (push && !full) begin
        encode_key(key_code, modifier_bits, has_text, text_code_point, cursor_app);
        for (int i = 0; i < seq_len; i++)
          expected_bytes.push_back('{value: seq_buf[i], tail: (i == seq_len - 1)});
      end
      if (cfg_valid && cfg_ready)
        cursor_app = app_cursor_mode;
    end
    bytes_pending = expected_bytes.size();
  end

endmodule : kses_sequence_checker

FILE: sim/key_to_escape_sequence_encoder_unit_test.sv
// testbench top of the key to escape sequence encoder: stimulus, idling and verdict
// depends on kses_pkg, kses_sequence_checker (with kses_tb_keys_pkg) and the encoder rtl
module key_to_escape_sequence_encoder_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  import kses_tb_keys_pkg::*;

  // run sizing
  localparam int PHASE_ITEMS     = 102;
  localparam int HOLD_OFF_CYCLES = 80;
  localparam int SETTLE_CYCLES   = 8;
  localparam int END_CYCLES      = 16;
  localparam int CYCLE_LIMIT     = 400000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        push = 1'b0;
  logic        full;
  logic [7:0]  key_code = '0;
  logic [2:0]  modifier_bits = '0;
  logic        has_text = 1'b0;
  logic [20:0] text_code_point = '0;
  logic        empty;
  logic        pop = 1'b0;
  logic [7:0]  out_byte;
  logic        last_byte;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic        app_cursor_mode = 1'b0;

  int mismatch_count;
  int bytes_pending;

  // idle chances in percent per cycle, and the receiver hold-off request
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_off_left = 0;
  int cycle_count = 0;

  key_to_escape_sequence_encoder_unit dut (
    .clk             (clk),
    .rst             (rst),
    .push            (push),
    .full            (full),
    .key_code        (key_code),
    .modifier_bits   (modifier_bits),
    .has_text        (has_text),
    .text_code_point (text_code_point),
    .empty           (empty),
    .pop             (pop),
    .out_byte        (out_byte),
    .last_byte       (last_byte),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .app_cursor_mode (app_cursor_mode)
  );

  kses_sequence_checker seq_check (
    .clk             (clk),
    .rst             (rst),
    .push            (push),
    .full            (full),
    .key_code        (key_code),
    .modifier_bits   (modifier_bits),
    .has_text        (has_text),
    .text_code_point (text_code_point),
    .empty           (empty),
    .pop             (pop),
    .out_byte        (out_byte),
    .last_byte       (last_byte),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .app_cursor_mode (app_cursor_mode),
    .mismatch_count  (mismatch_count),
    .bytes_pending   (bytes_pending)
  );

  // 2 ns clock
  initial begin
    forever #1 clk = ~clk;
  end

  // watchdog: a hung handshake ends the run here
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("TB_ERROR");
    $finish;
  end

  // byte receiver: random pop, or a long hold-off when one is requested
  initial begin
    forever begin
      @(negedge clk);
      if (hold_off_left > 0) begin
        pop = 1'b0;
        hold_off_left--;
      end else begin
        pop = ($urandom_range(99, 0) >= recv_idle_pct);
      end
    end
  end

  // offer one key request and hold it until taken; full is sampled before
  // the edge, so a low full at the edge means the request went in
  task automatic send_key(input logic [7:0] k, input logic [2:0] m, input logic t,
                          input logic [20:0] cp);
    key_code = k;
    modifier_bits = m;
    has_text = t;
    text_code_point = cp;
    push = 1'b1;
    @(posedge clk);
    while (full) @(posedge clk);
    @(negedge clk);
    // random sender gap before the next request
    while ($urandom_range(99, 0) < send_idle_pct) begin
      push = 1'b0;
      @(negedge clk);
    end
  endtask

  // stop offering and wait until every predicted byte has been popped
  task automatic wait_drained();
    push = 1'b0;
    while (bytes_pending != 0 || !empty) @(negedge clk);
  endtask

  // register write only with the encoder idle, after a drain and an extra settle;
  // keys that send no bytes never enter the queue
  task automatic write_cursor_mode(input logic value);
    wait_drained();
    repeat (SETTLE_CYCLES) @(negedge clk);
    app_cursor_mode = value;
    cfg_valid = 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // mostly real key classes with random modifiers and text, some raw noise
  task automatic random_key();
    logic [7:0]  k;
    logic [2:0]  m;
    logic        t;
    logic [20:0] cp;
    int unsigned pick;
    pick = $urandom_range(99, 0);
    if (pick < 40)
      k = 8'($urandom_range(KC_SCROLL_LOCK, KC_UP));     // special keys
    else if (pick < 75)
      k = 8'($urandom_range(8'h7E, KC_SPACE));           // printable keys
    else
      k = 8'($urandom());                                // anything
    m = 3'($urandom());
    t = ($urandom_range(9, 0) != 0);
    pick = $urandom_range(99, 0);
    if (pick < 35)
      cp = 21'($urandom_range(32'h7F, 0));               // one byte utf-8
    else if (pick < 55)
      cp = 21'($urandom_range(32'h7FF, 32'h80));         // two bytes
    else if (pick < 70)
      cp = 21'($urandom_range(32'hFFFF, 32'h800));       // three bytes
    else if (pick < 80)
      cp = 21'($urandom_range(32'h10FFFF, 32'h10000));   // four bytes
    else if (pick < 87)
      cp = 21'($urandom_range(32'hDFFF, 32'hD800));      // surrogates
    else
      cp = 21'($urandom());                              // includes out of range
    send_key(k, m, t, cp);
  endtask

  // one idling profile and cursor mode; partway through the sender waits for
  // a full drain, and later the receiver holds off so the queue fills
  task automatic run_phase(input int count, input int send_pct, input int recv_pct,
                           input logic mode);
    write_cursor_mode(mode);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    for (int i = 0; i < count; i++) begin
      if (i == count / 3)
        wait_drained();
      if (i == count / 2)
        hold_off_left = HOLD_OFF_CYCLES;
      random_key();
    end
  endtask

  initial begin
    repeat (4) @(negedge clk);
    rst = 1'b0;

    // directed keys, normal cursor mode, first idling profile
    write_cursor_mode(1'b0);
    send_idle_pct = 25;
    recv_idle_pct = 61;
    send_key(KC_UP, MOD_NONE, 1'b0, 21'h0);
    send_key(KC_HOME, MOD_ALL, 1'b1, 21'h41);             // CSI 1;8 H
    send_key(KC_LEFT, MOD_SHIFT, 1'b0, 21'h0);
    send_key(KC_INSERT, MOD_NONE, 1'b0, 21'h0);
    send_key(KC_PAGE_DOWN, MOD_ALL, 1'b0, 21'h0);
    send_key(KC_F1, MOD_NONE, 1'b0, 21'h0);
    send_key(KC_F4, MOD_CTRL, 1'b0, 21'h0);
    send_key(KC_F5, MOD_NONE, 1'b0, 21'h0);
    send_key(KC_F12, MOD_ALL, 1'b0, 21'h0);               // longest sequence
    send_key(KC_SHIFT, MOD_NONE, 1'b1, 21'h61);           // bare modifier, text ignored
    send_key(KC_SCROLL_LOCK, MOD_ALT, 1'b1, 21'h1FFFFF);
    send_key(KC_RETURN, MOD_ALT, 1'b0, 21'h0);
    send_key(KC_ENTER, MOD_NONE, 1'b0, 21'h0);
    send_key(KC_TAB, MOD_ALT, 1'b0, 21'h0);
    send_key(KC_BACKTAB, MOD_SHIFT, 1'b0, 21'h0);
    send_key(KC_ESCAPE, MOD_ALT, 1'b0, 21'h0);
    send_key(KC_BACKSPACE, MOD_CTRL | MOD_ALT, 1'b0, 21'h0);
    send_key(KC_BACKSPACE, MOD_NONE, 1'b0, 21'h0);
    send_key(KC_SPACE, MOD_CTRL | MOD_ALT, 1'b1, 21'h20);
    send_key(8'h5A, MOD_CTRL, 1'b1, 21'h5A);              // ctrl letter
    send_key(8'h36, MOD_CTRL, 1'b1, 21'h36);              // ctrl 6 punctuation code
    send_key(8'h61, MOD_CTRL, 1'b1, 21'h61);              // lower case goes to text
    send_key(8'h78, MOD_NONE, 1'b0, 21'h78);              // no text, no bytes
    send_key(8'h00, MOD_NONE, 1'b1, 21'h00D800);          // surrogate becomes U+FFFD
    send_key(8'hFF, MOD_ALT, 1'b1, 21'h1FFFFF);           // above range, alt prefix
    send_key(8'h51, MOD_NONE, 1'b1, 21'h0);               // code point zero
    send_key(8'hE9, MOD_ALT, 1'b1, 21'h10FFFF);

    // random phases, cursor mode toggled between its two values
    run_phase(PHASE_ITEMS, 25, 61, 1'b1);
    run_phase(PHASE_ITEMS, 61, 25, 1'b0);
    run_phase(PHASE_ITEMS, 0, 0, 1'b1);

    // let stray bytes surface before the verdict
    wait_drained();
    repeat (END_CYCLES) @(negedge clk);
    if (mismatch_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule : key_to_escape_sequence_encoder_unit_test
